FILE: rtl/edge_partition_router_defines.svh
`ifndef EDGE_PARTITION_ROUTER_DEFINES_SVH
`define EDGE_PARTITION_ROUTER_DEFINES_SVH

// same-cycle implication
`define EPR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("edge_partition_router assertion failed");

// next-cycle implication
`define EPR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("edge_partition_router assertion failed");

`endif

FILE: rtl/epr_pkg.sv
package epr_pkg;

  localparam int VW            = 48;
  localparam int WBW           = 32;
  localparam int WCW           = 9;
  localparam int DPW           = 10;
  localparam int SCW           = 6;
  localparam int PCRW          = 11;
  localparam int DEF_MAX_PARTS = 1024;
  localparam logic [SCW-1:0]  SCALE_MAX = 6'd48;
  localparam logic [SCW-1:0]  SCALE_RST = 6'd20;
  localparam logic [PCRW-1:0] PARTS_RST = 11'd1;

  typedef enum logic [0:0] {
    CFG_SCALE = 1'b0,
    CFG_PARTS = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_DIV,
    SEQ_MUL
  } seq_state_t;

  typedef struct packed {
    logic [VW-1:0] mask;
    logic [VW:0]   base;
    logic [VW:0]   thr;
  } geom_t;

  function automatic logic [WCW-1:0] weight_code_f(input logic [WBW-1:0] b);
    logic        neg;
    logic [7:0]  ex;
    logic [23:0] m;
    logic [7:0]  low;
    logic        nan;
    neg = b[31];
    ex  = b[30:23];
    m   = {1'b1, b[22:0]};
    nan = 1'b0;
    low = 8'd0;
    if (ex == 8'hFF) begin
      nan = (b[22:0] != 23'd0);
      low = neg ? 8'd0 : 8'd255;
    end else if (ex == 8'd0) begin
      low = 8'd0;
    end else if (ex >= 8'd150) begin
      low = neg ? 8'd0 : 8'd255;
    end else if (ex >= 8'd142) begin
      low = 8'(m << 3'(ex - 8'd142));
    end else if (ex >= 8'd111) begin
      low = 8'(m >> 5'(8'd142 - ex));
    end
    if (nan) begin
      return '0;
    end
    return neg ? (9'd0 - {1'b0, low}) : {1'b0, low};
  endfunction

endpackage

FILE: rtl/edge_partition_router.sv
// Pipeline: the path from input transaction to first result runs through two register
//   stages, one divider stage per owner bit and the output register.
// Throughput: one edge per cycle with out_tready high, config idle and a shared owner;
//   the single output register emits both copies of a split edge and stalls the input.
// Reset and every config write start a divide of the vertex count by the part count plus
//   a shift-add pass over the remainder bits; in_tready stays low meanwhile.
`include "edge_partition_router_defines.svh"
module edge_partition_router import epr_pkg::*; #(
  parameter int MAX_PARTS = DEF_MAX_PARTS
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [127:0]    in_tdata,   // start_raw[47:0], end_raw[95:48], weight_bits[127:96]
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [119:0]    out_tdata,  // dest_part[9:0], start_vertex[57:10],
                                      // end_vertex[105:58], weight_code[114:106], zero pad
  output logic            out_tlast,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  cfg_idx_t        cfg_index,
  input  logic [PCRW-1:0] cfg_data
);

  localparam int QW  = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
  localparam int PW  = $clog2(MAX_PARTS + 1);
  localparam int OWW = (QW > DPW) ? QW : DPW;

  geom_t          geom;
  logic [PW-1:0]  extras;
  logic           cfg_idle;
  logic           adv;

  logic           f_vld;
  logic [VW-1:0]  f_sv, f_ev, f_snum, f_enum;
  logic [VW:0]    f_sden, f_eden;
  logic [WCW-1:0] f_wc;
  logic [QW-1:0]  f_sadd, f_eadd;
  logic [QW-1:0]  qs, qe;

  logic           dl_v_r  [QW];
  logic [VW-1:0]  dl_sv_r [QW];
  logic [VW-1:0]  dl_ev_r [QW];
  logic [WCW-1:0] dl_wc_r [QW];
  logic [QW-1:0]  dl_sa_r [QW];
  logic [QW-1:0]  dl_ea_r [QW];

  logic [QW-1:0]  os, oe;
  logic [OWW-1:0] os_w, oe_w;

  logic           out_valid_r;
  logic           last_r;
  logic [DPW-1:0] dest_r;
  logic [DPW-1:0] oe_r;
  logic [VW-1:0]  sv_r, ev_r;
  logic [WCW-1:0] wc_r;

  epr_cfg #(.MAX_PARTS(MAX_PARTS)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geom      (geom),
    .extras    (extras),
    .idle      (cfg_idle)
  );

  assign adv       = !out_valid_r || (out_tready && last_r);
  assign in_tready = adv && cfg_idle;

  epr_front #(.MAX_PARTS(MAX_PARTS)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (adv),
    .in_ok       (in_tvalid && in_tready),
    .start_raw   (in_tdata[47:0]),
    .end_raw     (in_tdata[95:48]),
    .weight_bits (in_tdata[127:96]),
    .geom        (geom),
    .extras      (extras),
    .vld         (f_vld),
    .sv          (f_sv),
    .ev          (f_ev),
    .wc          (f_wc),
    .s_num       (f_snum),
    .s_den       (f_sden),
    .s_add       (f_sadd),
    .e_num       (f_enum),
    .e_den       (f_eden),
    .e_add       (f_eadd)
  );

  epr_div #(.QW(QW)) u_div_s (
    .clk (clk),
    .en  (adv),
    .num (f_snum),
    .den (f_sden),
    .quo (qs)
  );

  epr_div #(.QW(QW)) u_div_e (
    .clk (clk),
    .en  (adv),
    .num (f_enum),
    .den (f_eden),
    .quo (qe)
  );

  for (genvar i = 0; i < QW; i++) begin : g_dl
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dl_v_r[i] <= 1'b0;
      end else if (adv) begin
        dl_v_r[i] <= (i == 0) ? f_vld : dl_v_r[(i == 0) ? 0 : i-1];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dl_sv_r[i] <= (i == 0) ? f_sv   : dl_sv_r[(i == 0) ? 0 : i-1];
        dl_ev_r[i] <= (i == 0) ? f_ev   : dl_ev_r[(i == 0) ? 0 : i-1];
        dl_wc_r[i] <= (i == 0) ? f_wc   : dl_wc_r[(i == 0) ? 0 : i-1];
        dl_sa_r[i] <= (i == 0) ? f_sadd : dl_sa_r[(i == 0) ? 0 : i-1];
        dl_ea_r[i] <= (i == 0) ? f_eadd : dl_ea_r[(i == 0) ? 0 : i-1];
      end
    end
  end

  assign os   = dl_sa_r[QW-1] + qs;
  assign oe   = dl_ea_r[QW-1] + qe;
  assign os_w = OWW'(os);
  assign oe_w = OWW'(oe);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      last_r      <= 1'b1;
    end else if (adv) begin
      out_valid_r <= dl_v_r[QW-1];
      last_r      <= (os == oe);
    end else if (out_tready) begin
      last_r      <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dest_r <= os_w[DPW-1:0];
      oe_r   <= oe_w[DPW-1:0];
      sv_r   <= dl_sv_r[QW-1];
      ev_r   <= dl_ev_r[QW-1];
      wc_r   <= dl_wc_r[QW-1];
    end else if (out_tready) begin
      dest_r <= oe_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = last_r;
  assign out_tdata  = {5'd0, wc_r, ev_r, sv_r, dest_r};

  `EPR_ASSERT_NOW(a_ready_idle, in_tready, cfg_idle)
  `EPR_ASSERT_NEXT(a_pair_second, out_tvalid && out_tready && !out_tlast, out_tvalid && out_tlast)
  `EPR_ASSERT_NEXT(a_pair_dest, out_tvalid && out_tready && !out_tlast,
                   out_tdata[9:0] != $past(out_tdata[9:0]))

endmodule

FILE: rtl/epr_cfg.sv
module epr_cfg import epr_pkg::*; #(
  parameter int MAX_PARTS = DEF_MAX_PARTS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  cfg_idx_t                            cfg_index,
  input  logic [PCRW-1:0]                     cfg_data,
  output geom_t                               geom,
  output logic [$clog2(MAX_PARTS+1)-1:0]      extras,
  output logic                                idle
);

  localparam int PW = $clog2(MAX_PARTS + 1);

  seq_state_t      state_r, state_nxt;
  logic [SCW-1:0]  scale_r;
  logic [PCRW-1:0] parts_r;
  logic [SCW-1:0]  cnt_r, cnt_nxt;
  logic [PW-1:0]   rem_r, rem_nxt;
  logic [VW:0]     base_r, base_nxt;
  logic [VW:0]     thr_r, thr_nxt;
  logic [VW:0]     add_r, add_nxt;
  logic [PW-1:0]   ext_r, ext_nxt;
  logic [PW-1:0]   esh_r, esh_nxt;
  logic [VW-1:0]   mask_r, mask_nxt;
  logic [SCW-1:0]  s_eff;
  logic [PW-1:0]   p_eff;
  logic [PW:0]     rsh;
  logic            ge;
  logic            wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;
  assign s_eff     = (scale_r > SCALE_MAX) ? SCALE_MAX : scale_r;

  always_comb begin
    if (parts_r == '0) begin
      p_eff = PW'(1);
    end else if (32'(parts_r) > MAX_PARTS) begin
      p_eff = PW'(MAX_PARTS);
    end else begin
      p_eff = PW'(parts_r);
    end
  end

  assign rsh = {rem_r, (cnt_r == s_eff)};
  assign ge  = (rsh >= {1'b0, p_eff});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_DIV;
      scale_r <= SCALE_RST;
      parts_r <= PARTS_RST;
      cnt_r   <= SCALE_MAX;
      rem_r   <= '0;
      base_r  <= '0;
    end else if (wr) begin
      state_r <= SEQ_DIV;
      cnt_r   <= SCALE_MAX;
      rem_r   <= '0;
      base_r  <= '0;
      unique case (cfg_index)
        CFG_SCALE: scale_r <= SCW'(cfg_data);
        CFG_PARTS: parts_r <= cfg_data;
        default:   ;
      endcase
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      rem_r   <= rem_nxt;
      base_r  <= base_nxt;
    end
  end

  always_ff @(posedge clk) begin
    thr_r  <= thr_nxt;
    add_r  <= add_nxt;
    ext_r  <= ext_nxt;
    esh_r  <= esh_nxt;
    mask_r <= mask_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    base_nxt  = base_r;
    thr_nxt   = thr_r;
    add_nxt   = add_r;
    ext_nxt   = ext_r;
    esh_nxt   = esh_r;
    mask_nxt  = mask_r;
    unique case (state_r)
      SEQ_IDLE: ;
      SEQ_DIV: begin
        rem_nxt  = ge ? PW'(rsh - {1'b0, p_eff}) : rsh[PW-1:0];
        base_nxt = {base_r[VW-1:0], ge};
        cnt_nxt  = cnt_r - 6'd1;
        if (cnt_r == '0) begin
          state_nxt = SEQ_MUL;
          cnt_nxt   = '0;
          ext_nxt   = rem_nxt;
          esh_nxt   = rem_nxt;
          add_nxt   = base_nxt + 49'd1;
          thr_nxt   = '0;
          mask_nxt  = VW'(((VW+1)'(1) << s_eff) - (VW+1)'(1));
        end
      end
      SEQ_MUL: begin
        if (esh_r[0]) begin
          thr_nxt = thr_r + add_r;
        end
        add_nxt = add_r << 1;
        esh_nxt = esh_r >> 1;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == SCW'(PW - 1)) begin
          state_nxt = SEQ_IDLE;
        end
      end
      default: state_nxt = SEQ_IDLE;
    endcase
  end

  assign geom.mask = mask_r;
  assign geom.base = base_r;
  assign geom.thr  = thr_r;
  assign extras    = ext_r;
  assign idle      = (state_r == SEQ_IDLE);

endmodule

FILE: rtl/epr_front.sv
module epr_front import epr_pkg::*; #(
  parameter int MAX_PARTS = DEF_MAX_PARTS
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          en,
  input  logic                                          in_ok,
  input  logic [VW-1:0]                                 start_raw,
  input  logic [VW-1:0]                                 end_raw,
  input  logic [WBW-1:0]                                weight_bits,
  input  geom_t                                         geom,
  input  logic [$clog2(MAX_PARTS+1)-1:0]                extras,
  output logic                                          vld,
  output logic [VW-1:0]                                 sv,
  output logic [VW-1:0]                                 ev,
  output logic [WCW-1:0]                                wc,
  output logic [VW-1:0]                                 s_num,
  output logic [VW:0]                                   s_den,
  output logic [((MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1)-1:0] s_add,
  output logic [VW-1:0]                                 e_num,
  output logic [VW:0]                                   e_den,
  output logic [((MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1)-1:0] e_add
);

  localparam int QW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;

  logic           va_r, vb_r;
  logic [VW-1:0]  sva_r, eva_r, svb_r, evb_r;
  logic [WCW-1:0] wca_r, wcb_r;
  logic [VW-1:0]  sn_r, en_r;
  logic [VW:0]    sd_r, ed_r;
  logic [QW-1:0]  sa_r, ea_r;
  logic           s_lt, e_lt;
  logic [VW:0]    base_p1;

  assign base_p1 = geom.base + 49'd1;
  assign s_lt    = ({1'b0, sva_r} < geom.thr);
  assign e_lt    = ({1'b0, eva_r} < geom.thr);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (en) begin
      va_r <= in_ok;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sva_r <= start_raw & geom.mask;
      eva_r <= end_raw & geom.mask;
      wca_r <= weight_code_f(weight_bits);
      svb_r <= sva_r;
      evb_r <= eva_r;
      wcb_r <= wca_r;
      sn_r  <= s_lt ? sva_r : VW'(sva_r - geom.thr[VW-1:0]);
      sd_r  <= s_lt ? base_p1 : geom.base;
      sa_r  <= s_lt ? '0 : QW'(extras);
      en_r  <= e_lt ? eva_r : VW'(eva_r - geom.thr[VW-1:0]);
      ed_r  <= e_lt ? base_p1 : geom.base;
      ea_r  <= e_lt ? '0 : QW'(extras);
    end
  end

  assign vld   = vb_r;
  assign sv    = svb_r;
  assign ev    = evb_r;
  assign wc    = wcb_r;
  assign s_num = sn_r;
  assign s_den = sd_r;
  assign s_add = sa_r;
  assign e_num = en_r;
  assign e_den = ed_r;
  assign e_add = ea_r;

endmodule

FILE: rtl/epr_div.sv
module epr_div import epr_pkg::*; #(
  parameter int QW = 10
) (
  input  logic          clk,
  input  logic          en,
  input  logic [VW-1:0] num,
  input  logic [VW:0]   den,
  output logic [QW-1:0] quo
);

  logic [VW-1:0] rem_r [QW];
  logic [VW:0]   den_r [QW];
  logic [QW-1:0] q_r   [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [VW-1:0]   rem_in;
    logic [VW:0]     den_in;
    logic [QW-1:0]   q_in;
    logic [VW+QW:0]  trial;
    logic            ge;
    if (i == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign den_in = den_r[i-1];
      assign q_in   = q_r[i-1];
    end
    assign trial = (VW+QW+1)'(den_in) << (QW - 1 - i);
    assign ge    = ((VW+QW+1)'(rem_in) >= trial);
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? VW'((VW+QW+1)'(rem_in) - trial) : rem_in;
        den_r[i] <= den_in;
        q_r[i]   <= {q_in[QW-2:0] , ge} ;
      end
    end
  end

  assign quo = q_r[QW-1];

endmodule
